// ----- sv/assert_macros.svh -----
// Assertion macros shared by the tilt-angle dial modules.
// Included by every RTL file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/atad_pkg.sv -----
// Package for the tilt-angle dial: widths, state and command types, arctangent table
// and the dial tick function. Has no dependencies; used by every module of the block.
package atad_pkg;

    localparam int IDX_W      = 5;
    localparam int ROOT_STEPS = 24;
    localparam int TICK_COUNT = 13;
    localparam int ANGLE_W    = 12;
    localparam int X_W        = 27;
    localparam int Z_W        = 25;
    localparam int ATAN_W     = 23;

    localparam logic signed [Z_W-1:0] Z_MAX   = 25'sd5898240;
    localparam logic [10:0]           MAG_MAX = 11'd1440;

    localparam logic REG_STROBE_PERIOD = 1'b0;
    localparam logic REG_REDRAW_THR    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQY,
        ST_SQZ,
        ST_ROOT,
        ST_PREP,
        ST_ROT,
        ST_ANGLE,
        ST_COMMIT
    } atad_state_t;

    typedef struct packed {
        logic             load;
        logic             sq_y;
        logic             sq_z;
        logic             root;
        logic             prep;
        logic             rot;
        logic             angle;
        logic             commit;
        logic [IDX_W-1:0] idx;
    } atad_cmd_t;

    // atan(2^-i) in 2^-16 degree, rounded.
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // Tick i sits at -90 + 15*i degrees; it is lit when it lies between zero and
    // the angle, both ends included.
    function automatic logic [TICK_COUNT-1:0] ticks_for(input logic signed [ANGLE_W-1:0] d);
        logic [TICK_COUNT-1:0] want;
        int                    dv;
        int                    a;
        want = '0;
        dv   = int'(d);
        for (int i = 0; i < TICK_COUNT; i++) begin
            a = -90 + 15 * i;
            if (dv >= 0)
                want[i] = (a >= 0) && (a * 16 <= dv);
            else
                want[i] = (a <= 0) && (a * 16 >= dv);
        end
        return want;
    endfunction

endpackage

// ----- sv/atad_ctrl.sv -----
// Sequencer of the tilt-angle dial: state machine, step counter and output-valid flag.
// Depends on atad_pkg and assert_macros.svh; drives the datapath through atad_cmd_t.
`include "assert_macros.svh"

module atad_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output atad_pkg::atad_cmd_t cmd
);
    import atad_pkg::*;

    localparam logic [IDX_W-1:0] ROOT_LAST = IDX_W'(ROOT_STEPS - 1);
    localparam logic [IDX_W-1:0] ROT_LAST  = IDX_W'(CORDIC_STEPS - 1);

    atad_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SQY;
            end
            ST_SQY:
                state_next = ST_SQZ;
            ST_SQZ:
            begin
                state_next = ST_ROOT;
                cnt_next   = ROOT_LAST;
            end
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                    state_next = ST_PREP;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_PREP:
            begin
                state_next = ST_ROT;
                cnt_next   = '0;
            end
            ST_ROT:
            begin
                if (cnt_reg == ROT_LAST)
                    state_next = ST_ANGLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_ANGLE:
                state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb
    begin
        cmd            = '0;
        cmd.idx        = cnt_reg;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SQY:   cmd.sq_y  = 1'b1;
            ST_SQZ:   cmd.sq_z  = 1'b1;
            ST_ROOT:  cmd.root  = 1'b1;
            ST_PREP:  cmd.prep  = 1'b1;
            ST_ROT:   cmd.rot   = 1'b1;
            ST_ANGLE: cmd.angle = 1'b1;
            ST_COMMIT:
            begin
                cmd.commit = slot_free;
                if (slot_free)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    `ASSERT_CLK(a_no_overwrite, clk, rst_n, cmd.commit |-> (!m_tvalid || m_tready), "result overwritten before transfer")
    `ASSERT_CLK(a_one_at_a_time, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "second sample taken while one is in work")
    `ASSERT_CLK(a_valid_from_commit, clk, rst_n, $rose(m_tvalid) |-> $past(cmd.commit), "result valid without a commit")

endmodule

// ----- sv/atad_dp.sv -----
// Datapath of the tilt-angle dial: squares, digit-by-digit root, shared CORDIC stage,
// angle rounding, and the label, dial and history state.
// Depends on atad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module atad_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  atad_pkg::atad_cmd_t            cmd,
    input  logic signed [15:0]             accel_x,
    input  logic signed [15:0]             accel_y,
    input  logic signed [15:0]             accel_z,
    input  logic [3:0]                     strobe_period,
    input  logic [10:0]                    redraw_threshold,
    output logic signed [11:0]             tilt_angle,
    output logic                           label_update,
    output logic                           dial_update,
    output logic [12:0]                    tick_mask,
    output logic [12:0]                    tick_toggle,
    output logic                           hist_strobe,
    output logic [15:0]                    hist_index
);
    import atad_pkg::*;

    // Sample and arithmetic registers.
    logic signed [15:0]        ax_reg, ay_reg, az_reg;
    logic [31:0]               sq_reg;
    logic [47:0]               s_reg, res_reg;
    logic signed [X_W-1:0]     x_reg, y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic signed [ANGLE_W-1:0] ang_reg;

    // Persistent block state.
    logic                      label_phase_reg, dial_phase_reg, needle_set_reg;
    logic signed [ANGLE_W-1:0] dial_last_reg;
    logic [TICK_COUNT-1:0]     shown_reg;
    logic [3:0]                hist_phase_reg;
    logic [15:0]               hist_count_reg;

    // Combinational terms.
    logic signed [15:0]        mul_op;
    logic signed [31:0]        prod;
    logic [31:0]               sq_sum;
    logic [47:0]               bit_val, trial;
    logic [16:0]               ax_abs;
    logic signed [X_W-1:0]     xs, ys;
    logic signed [Z_W-1:0]     atan_val, zc;
    logic [23:0]               rnd;
    logic [10:0]               mag;
    logic signed [ANGLE_W-1:0] ang_next;

    logic                      label_now, eval_now, redraw;
    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W:0]          diff_abs;
    logic [TICK_COUNT-1:0]     want, toggle, shown_next;
    logic [3:0]                hp_inc, hp_next;
    logic                      hstrobe;

    assign mul_op   = cmd.sq_z ? az_reg : ay_reg;
    assign prod     = mul_op * mul_op;
    assign sq_sum   = sq_reg + 32'(prod);

    assign bit_val  = 48'd1 << {cmd.idx, 1'b0};
    assign trial    = res_reg + bit_val;

    assign ax_abs   = ax_reg[15] ? (17'd0 - {ax_reg[15], ax_reg}) : {1'b0, ax_reg};

    assign xs       = x_reg >>> cmd.idx;
    assign ys       = y_reg >>> cmd.idx;
    assign atan_val = $signed({2'b00, atan_lut(cmd.idx)});

    // Clamp the accumulated angle to the first quadrant, then round to 1/16 degree.
    always_comb
    begin
        if (z_reg < 0)
            zc = '0;
        else if (z_reg > Z_MAX)
            zc = Z_MAX;
        else
            zc = z_reg;
        rnd = {1'b0, zc[22:0]} + 24'd2048;
        if (rnd[23:12] > {1'b0, MAG_MAX})
            mag = MAG_MAX;
        else
            mag = rnd[22:12];
        // A zero x axis gives zero; a purely vertical sample is a full right angle.
        if (ax_reg == '0)
            mag = '0;
        else if (ay_reg == '0 && az_reg == '0)
            mag = MAG_MAX;
        ang_next = ax_reg[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Label, dial and history decisions for the sample being committed.
    always_comb
    begin
        label_now  = label_phase_reg;
        eval_now   = label_now && dial_phase_reg;
        diff       = {ang_reg[ANGLE_W-1], ang_reg}
                     - {dial_last_reg[ANGLE_W-1], dial_last_reg};
        diff_abs   = diff[ANGLE_W] ? ((ANGLE_W + 1)'(0) - diff) : diff;
        redraw     = eval_now && (!needle_set_reg || diff_abs >= {2'b00, redraw_threshold});
        want       = ticks_for(ang_reg);
        toggle     = redraw ? (want ^ shown_reg) : '0;
        shown_next = redraw ? want : shown_reg;
        hp_inc     = hist_phase_reg + 4'd1;
        hstrobe    = hp_inc >= strobe_period;
        hp_next    = hstrobe ? 4'd0 : hp_inc;
    end

    // Working registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
        end
        if (cmd.sq_y)
            sq_reg <= 32'(prod);
        if (cmd.sq_z)
        begin
            s_reg   <= {sq_sum, 16'd0};
            res_reg <= '0;
        end
        if (cmd.root)
        begin
            if (s_reg >= trial)
            begin
                s_reg   <= s_reg - trial;
                res_reg <= (res_reg >> 1) + bit_val;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
        if (cmd.prep)
        begin
            x_reg <= $signed({3'b000, res_reg[23:0]});
            y_reg <= $signed({2'b00, ax_abs, 8'd0});
            z_reg <= '0;
        end
        if (cmd.rot)
        begin
            if (!y_reg[X_W-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_val;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_val;
            end
        end
        if (cmd.angle)
            ang_reg <= ang_next;
        if (cmd.commit)
        begin
            tilt_angle   <= ang_reg;
            label_update <= label_now;
            dial_update  <= redraw;
            tick_mask    <= shown_next;
            tick_toggle  <= toggle;
            hist_strobe  <= hstrobe;
            hist_index   <= hist_count_reg + {15'd0, hstrobe};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_phase_reg <= 1'b0;
            dial_phase_reg  <= 1'b0;
            dial_last_reg   <= '0;
            needle_set_reg  <= 1'b0;
            shown_reg       <= '1;
            hist_phase_reg  <= '0;
            hist_count_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            label_phase_reg <= ~label_phase_reg;
            if (label_now)
                dial_phase_reg <= ~dial_phase_reg;
            if (redraw)
            begin
                dial_last_reg  <= ang_reg;
                needle_set_reg <= 1'b1;
            end
            shown_reg      <= shown_next;
            hist_phase_reg <= hp_next;
            hist_count_reg <= hist_count_reg + {15'd0, hstrobe};
        end
    end

    `ASSERT_CLK(a_angle_range, clk, rst_n, cmd.commit |-> (ang_reg <= 1440 && ang_reg >= -1440), "angle outside a right angle")
    `ASSERT_CLK(a_dial_on_label, clk, rst_n, cmd.commit |=> (!dial_update || label_update), "dial redrawn off a label strobe")
    `ASSERT_CLK(a_toggle_quiet, clk, rst_n, cmd.commit |=> (dial_update || tick_toggle == '0), "tick toggles without a redraw")

endmodule

// ----- sv/accel_tilt_angle_dial_top.sv -----
// Top level of the accelerometer tilt-angle dial: stream ports, configuration registers,
// and the sequencer and datapath. Depends on atad_pkg, atad_ctrl and atad_dp.
//
// Use of the block:
// A sample transfer on the s_ channel carries one 3-axis reading. The block returns exactly
// one result transfer on the m_ channel per sample: the tilt angle of the x axis in 1/16
// degree, the label and dial strobes with the 13-tick lit mask and its toggle mask, and the
// history strobe with its wrapping point count.
// One sample is worked on at a time. It passes through squaring on the shared 16 by 16
// multiplier, the digit-by-digit square root, a set-up step, the rotations of the shared
// CORDIC stage, and the rounding and dial update that commit the result to the output.
// A new sample is taken only once the sequencer has returned to idle after that commit.
// The output register holds a result until it is taken, so the next sample is accepted while
// it waits; only if that next result is ready before the receiver takes the first does the
// block hold it, and s_tready stays low until the output register is free.
// Reset clears the sequencer, the phases, the history count and the shown ticks (all lit) and
// returns the registers to a history period of 4 and redraw_threshold = 16. Registers are
// to be written through the APB port only while the block is idle; the block does not check.

module accel_tilt_angle_dial_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Sample channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // tilt_angle [11:0], label_update [12], dial_update [13],
                                   // tick_mask [26:14], tick_toggle [39:27],
                                   // hist_strobe [40], hist_index [56:41], zero [63:57]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import atad_pkg::*;

    atad_cmd_t          cmd;
    logic [3:0]         strobe_period_reg;
    logic [10:0]        redraw_thr_reg;
    logic               cfg_write;

    logic signed [11:0] tilt_angle;
    logic               label_update, dial_update, hist_strobe;
    logic [12:0]        tick_mask, tick_toggle;
    logic [15:0]        hist_index;

    // The port never waits; a write completes in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_period_reg <= 4'd4;
            redraw_thr_reg    <= 11'd16;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_STROBE_PERIOD: strobe_period_reg <= pwdata[3:0];
                REG_REDRAW_THR:    redraw_thr_reg    <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STROBE_PERIOD: prdata = {28'd0, strobe_period_reg};
            REG_REDRAW_THR:    prdata = {21'd0, redraw_thr_reg};
            default:           prdata = '0;
        endcase
    end

    atad_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    atad_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .accel_x          ($signed(s_tdata[15:0])),
        .accel_y          ($signed(s_tdata[31:16])),
        .accel_z          ($signed(s_tdata[47:32])),
        .strobe_period    (strobe_period_reg),
        .redraw_threshold (redraw_thr_reg),
        .tilt_angle       (tilt_angle),
        .label_update     (label_update),
        .dial_update      (dial_update),
        .tick_mask        (tick_mask),
        .tick_toggle      (tick_toggle),
        .hist_strobe      (hist_strobe),
        .hist_index       (hist_index)
    );

    assign m_tdata = {7'd0, hist_index, hist_strobe, tick_toggle, tick_mask,
                      dial_update, label_update, tilt_angle};

endmodule

// ----- tb/sv/accel_tilt_angle_dial_top_test.sv -----
// Self-checking testbench for the accelerometer tilt-angle dial: a scoreboard class
// predicts every result transfer from the accepted samples and the register settings.
// Depends on atad_pkg and accel_tilt_angle_dial_top; reads no files.

// One result transfer, laid out as m_tdata carries it (lowest field last).
typedef struct packed {
    bit [15:0]        hist_index;
    bit               hist_strobe;
    bit [12:0]        tick_toggle;
    bit [12:0]        tick_mask;
    bit               dial_update;
    bit               label_update;
    bit signed [11:0] tilt_angle;
} dial_result_t;

typedef struct packed {
    bit signed [15:0] az;
    bit signed [15:0] ay;
    bit signed [15:0] ax;
} accel_reading_t;

// atan(2^-i) in 2^-16 degree, rounded to nearest.
localparam longint ATAN_STEP [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
};

class tilt_dial_scoreboard;
    int               cordic_steps;
    bit [3:0]         strobe_period;
    bit [10:0]        redraw_thr;
    bit               label_phase;
    bit               dial_phase;
    bit               needle_set;
    bit signed [11:0] dial_last_angle;
    bit [12:0]        shown_ticks;
    bit [3:0]         hist_phase;
    bit [15:0]        hist_count;
    dial_result_t     expected_q[$];
    int unsigned      mismatches;

    function new(int steps);
        cordic_steps    = steps;
        strobe_period   = 4'd4;
        redraw_thr      = 11'd16;
        label_phase     = 1'b0;
        dial_phase      = 1'b0;
        needle_set      = 1'b0;
        dial_last_angle = '0;
        shown_ticks     = '1;
        hist_phase      = '0;
        hist_count      = '0;
        mismatches      = 0;
    endfunction

    function void set_register(bit idx, bit [31:0] value);
        if (idx == atad_pkg::REG_STROBE_PERIOD)
            strobe_period = value[3:0];
        else
            redraw_thr = value[10:0];
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Vectoring CORDIC on (sqrt(y^2 + z^2), |x|); the result is in 1/16 degree.
    function int tilt_angle_of(longint ax, longint ay, longint az);
        longint unsigned sq;
        longint unsigned root;
        longint unsigned probe;
        longint          x;
        longint          y;
        longint          z;
        longint          xo;
        longint          mag;
        if (ax == 0)
            return 0;
        if (ay == 0 && az == 0)
            return (ax > 0) ? 1440 : -1440;
        sq    = longint'(ay * ay + az * az) << 16;
        root  = 0;
        probe = 64'd1 << 48;
        while (probe > sq)
            probe >>= 2;
        while (probe != 0) begin
            if (sq >= root + probe) begin
                sq   = sq - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        x = root;
        y = ((ax < 0) ? -ax : ax) * 256;
        z = 0;
        for (int i = 0; i < cordic_steps && i < 24; i++) begin
            xo = x;
            if (y >= 0) begin
                x = x + (y >>> i);
                y = y - (xo >>> i);
                z = z + ATAN_STEP[i];
            end
            else begin
                x = x - (y >>> i);
                y = y + (xo >>> i);
                z = z - ATAN_STEP[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > 90 * 65536)
            z = 90 * 65536;
        mag = (z + 2048) >>> 12;
        if (mag > 1440)
            mag = 1440;
        return (ax < 0) ? -int'(mag) : int'(mag);
    endfunction

    // Tick i stands at -90 + 15*i degrees and is lit between zero and the angle.
    function bit [12:0] lit_ticks(int ang);
        bit [12:0] lit;
        int        tick_deg;
        lit = '0;
        for (int i = 0; i < 13; i++) begin
            tick_deg = -90 + 15 * i;
            if (ang >= 0)
                lit[i] = (tick_deg >= 0) && (tick_deg * 16 <= ang);
            else
                lit[i] = (tick_deg <= 0) && (tick_deg * 16 >= ang);
        end
        return lit;
    endfunction

    function void predict_reading(bit signed [15:0] ax, bit signed [15:0] ay,
                                  bit signed [15:0] az);
        dial_result_t r;
        int           ang;
        int           diff;
        bit [12:0]    lit;
        r   = '0;
        ang = tilt_angle_of(ax, ay, az);
        r.tilt_angle = ang[11:0];
        label_phase  = ~label_phase;
        if (!label_phase) begin
            r.label_update = 1'b1;
            dial_phase     = ~dial_phase;
            if (!dial_phase) begin
                diff = ang - int'(dial_last_angle);
                if (diff < 0)
                    diff = -diff;
                if (!needle_set || diff >= int'(redraw_thr)) begin
                    lit             = lit_ticks(ang);
                    r.dial_update   = 1'b1;
                    r.tick_toggle   = lit ^ shown_ticks;
                    shown_ticks     = lit;
                    dial_last_angle = ang[11:0];
                    needle_set      = 1'b1;
                end
            end
        end
        hist_phase = hist_phase + 4'd1;
        if (hist_phase >= strobe_period) begin
            hist_phase    = '0;
            r.hist_strobe = 1'b1;
            hist_count    = hist_count + 16'd1;
        end
        r.tick_mask  = shown_ticks;
        r.hist_index = hist_count;
        expected_q.push_back(r);
    endfunction

    function void compare_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(bit [63:0] word);
        dial_result_t want;
        dial_result_t got;
        if (expected_q.size() == 0) begin
            $error("result transfer %h arrived with no sample outstanding", word);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        got  = dial_result_t'(word[56:0]);
        compare_field("tilt_angle", want.tilt_angle, got.tilt_angle);
        compare_field("label_update", want.label_update, got.label_update);
        compare_field("dial_update", want.dial_update, got.dial_update);
        compare_field("tick_mask", want.tick_mask, got.tick_mask);
        compare_field("tick_toggle", want.tick_toggle, got.tick_toggle);
        compare_field("hist_strobe", want.hist_strobe, got.hist_strobe);
        compare_field("hist_index", want.hist_index, got.hist_index);
    endfunction
endclass

module accel_tilt_angle_dial_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS           = 16;
    // Time from a sample to its result, plus the return to idle before the next sample.
    localparam int LATENCY         = STEPS + 30;
    localparam int ITEMS_PER_PHASE = 172;
    localparam int PHASES          = 8;
    // Worst quiet stretch in a correct run is a long sender gap or a long receiver stall
    // on top of a full CORDIC pass; the limit is well above that.
    localparam int WATCHDOG_LIMIT  = 4000;

    // Register settings per phase. Both extremes of each field are visited, including a
    // zero history period and a zero threshold, and the history period drops from 15 to 1
    // between the second and third phases so that the phase counter is caught beyond it.
    localparam int PERIOD_SET [PHASES] = '{0, 15, 1, 7, 3, 11, 2, 4};
    localparam int THRESH_SET [PHASES] = '{0, 2047, 1440, 1, 16, 64, 300, 16};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // tilt_angle [11:0], label_update [12], dial_update [13],
                                 // tick_mask [26:14], tick_toggle [39:27],
                                 // hist_strobe [40], hist_index [56:41]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Idling percentages for the current phase, and the long receiver stall in progress.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned stall_left     = 0;
    int unsigned quiet_cycles   = 0;

    // A slowly wandering reading, so that the dial sees small angle changes that land on
    // both sides of the redraw threshold.
    int drift_x = 0;
    int drift_y = 0;
    int drift_z = 1000;

    tilt_dial_scoreboard results = new(STEPS);

    accel_tilt_angle_dial_top #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Receiver back-pressure. m_tready drops at random; now and then a long stall
    // holds the output register long enough for the next result to be finished and held.
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
            m_tready <= 1'b0;
            if ($urandom_range(99) < 4)
                stall_left <= $urandom_range(80, 10);
        end
        else
            m_tready <= 1'b1;
    end

    // Both channels are sampled at the rising edge, before any nonblocking update of that
    // edge takes effect, so each transfer is seen exactly once.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                results.predict_reading(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
            if (m_tvalid && m_tready)
                results.check_result(m_tdata);
        end
    end

    // A run that stops making progress on either channel is a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL accel_tilt_angle_dial_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic bit [15:0] edge_value();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Random readings: mostly the wandering reading and realistic milli-g values, with
    // full-range noise and the zero-x, vertical and extreme cases mixed in.
    function automatic accel_reading_t next_reading();
        accel_reading_t rd;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            if ($urandom_range(99) < 5) begin
                drift_x = $urandom_range(4096) - 2048;
                drift_y = $urandom_range(4096) - 2048;
                drift_z = $urandom_range(4096) - 2048;
            end
            drift_x = clamp16(drift_x + $urandom_range(64) - 32);
            drift_y = clamp16(drift_y + $urandom_range(64) - 32);
            drift_z = clamp16(drift_z + $urandom_range(64) - 32);
            rd.ax = 16'(drift_x);
            rd.ay = 16'(drift_y);
            rd.az = 16'(drift_z);
        end
        else if (pick < 65) begin
            rd.ax = 16'($urandom_range(4096) - 2048);
            rd.ay = 16'($urandom_range(4096) - 2048);
            rd.az = 16'($urandom_range(4096) - 2048);
        end
        else if (pick < 85)
            rd = {16'($urandom()), $urandom()};
        else if (pick < 90) begin
            rd    = {16'($urandom()), $urandom()};
            rd.ax = '0;
        end
        else if (pick < 95) begin
            rd.ax = 16'($urandom());
            rd.ay = '0;
            rd.az = '0;
        end
        else begin
            rd.ax = edge_value();
            rd.ay = edge_value();
            rd.az = edge_value();
        end
        return rd;
    endfunction

    // Offers one sample and returns at the edge where it is taken. With no gap due, valid
    // simply stays high from the previous transfer.
    task automatic send_reading(input accel_reading_t rd);
        int gap;
        gap = 0;
        if (src_idle_pct != 0) begin
            if ($urandom_range(99) < 8)
                gap = $urandom_range(60, 1);
            else
                while ($urandom_range(99) < src_idle_pct)
                    gap++;
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_axes(input int ax, input int ay, input int az);
        accel_reading_t rd;
        rd.ax = 16'(ax);
        rd.ay = 16'(ay);
        rd.az = 16'(az);
        send_reading(rd);
    endtask

    // The sender holds back until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results.pending() != 0);
    endtask

    // Setup cycle, then the access cycle at whose closing edge the register is written.
    task automatic write_register(input bit idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        results.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset settings, without idling: the all-zero sample, a
        // zero x axis, both vertical directions, the extremes of every axis, small and
        // near-45-degree angles of both signs. Every fourth sample evaluates the dial, the
        // first of those redrawing whatever the threshold.
        send_axes(0, 0, 0);
        send_axes(0, 1000, -1000);
        send_axes(32767, 0, 0);
        send_axes(-32768, 0, 0);
        send_axes(-32768, -32768, -32768);
        send_axes(32767, 32767, 32767);
        send_axes(1, 32767, -32768);
        send_axes(-1, 0, 1);
        send_axes(1000, 1000, 0);
        send_axes(-1000, 0, -1000);
        send_axes(1000, 0, 0);
        send_axes(707, 0, 707);
        send_axes(-707, 707, 0);
        send_axes(16384, -16384, 0);
        send_axes(-1, -1, -1);
        send_axes(100, 0, 1000);
        send_axes(-100, 1000, 0);
        send_axes(500, -866, 0);
        send_axes(-866, 0, 500);
        send_axes(32767, 1, 0);

        // Random phases. Each starts from an idle block, so the sender waits for every
        // outstanding result before the registers are rewritten.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            repeat (8) @(posedge clk);
            write_register(atad_pkg::REG_STROBE_PERIOD, PERIOD_SET[p]);
            write_register(atad_pkg::REG_REDRAW_THR, THRESH_SET[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_reading(next_reading());
        end

        drain_results();
        repeat (LATENCY) @(posedge clk);
        if (results.mismatches == 0 && results.pending() == 0)
            $display("PASS accel_tilt_angle_dial_top");
        else
            $display("FAIL accel_tilt_angle_dial_top");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/atad_pkg.sv
sv/atad_ctrl.sv
sv/atad_dp.sv
sv/accel_tilt_angle_dial_top.sv
tb/sv/accel_tilt_angle_dial_top_test.sv
